@@ rtl/core/jos_pkg.sv @@
// ----------------------------------------------------------------------------
// jos_pkg
// Shared widths, defaults and controller/datapath interface types for the
// Josephus elimination order block.
// ----------------------------------------------------------------------------
package jos_pkg;

	localparam int MAX_MEMBERS_DEF = 64;
	localparam int SIZE_FIELD_W    = 7;
	localparam int STEP_FIELD_W    = 16;
	localparam int POS_FIELD_W     = 7;

	// controller -> datapath
	typedef struct packed {
		logic start;      // load a new request
		logic mod_start;  // launch step % alive
		logic load_need;  // capture reduced step
		logic scan_step;  // examine one slot
		logic emit;       // remove victim, load result register
	} jos_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic size_zero;
		logic mod_done;
		logic scan_done;
		logic last_round;
		logic out_free;
	} jos_stat_t;

endpackage

@@ rtl/core/jos_mod_unit.sv @@
// ----------------------------------------------------------------------------
// jos_mod_unit
// Iterative restoring remainder: one dividend bit per cycle; done is high for a
// single cycle, registered on the same edge that loads the final remainder.
// ----------------------------------------------------------------------------
module jos_mod_unit
	import jos_pkg::*;
#(
	parameter int DIV_W = 7
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [STEP_FIELD_W-1:0] dividend,
	input  logic [DIV_W-1:0]        divisor,
	output logic                    done,
	output logic [DIV_W-1:0]        remainder
);

	localparam int CNT_W = $clog2(STEP_FIELD_W + 1);

	logic [CNT_W-1:0]        cnt_q;
	logic                    done_q;
	logic [STEP_FIELD_W-1:0] quo_q;
	logic [DIV_W-1:0]        rem_q;

	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   dsr_ext;
	logic [DIV_W:0]   diff;
	logic [DIV_W-1:0] rem_next;

	always_comb begin
		trial    = {rem_q, quo_q[STEP_FIELD_W-1]};
		dsr_ext  = {1'b0, divisor};
		diff     = trial - dsr_ext;
		rem_next = (trial >= dsr_ext) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(STEP_FIELD_W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - CNT_W'(1);
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[STEP_FIELD_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < divisor))
		else $error("remainder not below divisor");

endmodule

@@ rtl/core/jos_datapath.sv @@
// ----------------------------------------------------------------------------
// jos_datapath
// Request registers, removed map, circular scan, reduced step and the
// result register.
// ----------------------------------------------------------------------------
module jos_datapath
	import jos_pkg::*;
#(
	parameter int MAX_MEMBERS = MAX_MEMBERS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  jos_cmd_t                cmd,
	output jos_stat_t               stat,
	input  logic [SIZE_FIELD_W-1:0] circle_size,
	input  logic [STEP_FIELD_W-1:0] step_count,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [POS_FIELD_W-1:0]  eliminated_position,
	output logic                    last_of_run
);

	localparam int SW = $clog2(MAX_MEMBERS + 1);
	localparam int PW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;

	logic [SW-1:0]           size_q;
	logic [SW-1:0]           alive_q;
	logic [STEP_FIELD_W-1:0] step_q;
	logic [PW-1:0]           scan_q;
	logic [SW-1:0]           steps_q;
	logic [SW-1:0]           need_q;
	logic [PW-1:0]           victim_q;
	logic [MAX_MEMBERS-1:0]  removed_q;
	logic                    out_valid_q;
	logic [POS_FIELD_W-1:0]  out_pos_q;
	logic                    out_last_q;

	logic [SW-1:0] size_sat;
	logic          mod_done;
	logic [SW-1:0] mod_rem;
	logic          hit;
	logic [SW-1:0] steps_inc;
	logic          wrap;
	logic          out_free;

	always_comb begin
		size_sat  = (circle_size > SIZE_FIELD_W'(MAX_MEMBERS)) ? SW'(MAX_MEMBERS)
			: circle_size[SW-1:0];
		hit       = !removed_q[scan_q];
		steps_inc = steps_q + SW'(1);
		wrap      = (SW'(scan_q) == (size_q - SW'(1)));
		out_free  = !out_valid_q || out_ready;
	end

	jos_mod_unit #(
		.DIV_W(SW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mod_start),
		.dividend (step_q),
		.divisor  (alive_q),
		.done     (mod_done),
		.remainder(mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			removed_q   <= '0;
			scan_q      <= '0;
			alive_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				removed_q <= '0;
				scan_q    <= '0;
				alive_q   <= size_sat;
			end else if (cmd.scan_step) begin
				scan_q <= wrap ? '0 : scan_q + PW'(1);
			end else if (cmd.emit) begin
				removed_q[victim_q] <= 1'b1;
				alive_q             <= alive_q - SW'(1);
			end
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			size_q <= size_sat;
			step_q <= step_count;
		end
		if (cmd.load_need) begin
			need_q  <= (mod_rem == '0) ? alive_q : mod_rem;
			steps_q <= '0;
		end else if (cmd.scan_step && hit) begin
			steps_q  <= steps_inc;
			victim_q <= scan_q;
		end
		if (cmd.emit) begin
			out_pos_q  <= POS_FIELD_W'(victim_q) + POS_FIELD_W'(1);
			out_last_q <= (alive_q == SW'(1));
		end
	end

	always_comb begin
		stat.size_zero  = (circle_size == '0);
		stat.mod_done   = mod_done;
		stat.scan_done  = hit && (steps_inc == need_q);
		stat.last_round = (alive_q == SW'(1));
		stat.out_free   = out_free;
	end

	assign out_valid           = out_valid_q;
	assign eliminated_position = out_pos_q;
	assign last_of_run         = out_last_q;

	a_scan_in_circle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> (SW'(scan_q) < size_q))
		else $error("scan outside circle");

	a_victim_alive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !removed_q[victim_q])
		else $error("victim already removed");

	a_emit_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("result register overwritten");

	a_run_empties_circle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && stat.last_round) |=> (alive_q == '0))
		else $error("circle not empty after last beat");

endmodule

@@ rtl/core/jos_ctrl.sv @@
// ----------------------------------------------------------------------------
// jos_ctrl
// Round sequencer: reduce step, scan to victim, emit result.
// ----------------------------------------------------------------------------
module jos_ctrl
	import jos_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output jos_cmd_t  cmd,
	input  jos_stat_t stat
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MODS = 3'd1;
	localparam logic [2:0] ST_MODW = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		in_ready      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && !stat.size_zero) begin
					cmd.start = 1'b1;
					state_d   = ST_MODS;
				end
			end
			ST_MODS: begin
				cmd.mod_start = 1'b1;
				state_d       = ST_MODW;
			end
			ST_MODW: begin
				if (stat.mod_done) begin
					cmd.load_need = 1'b1;
					state_d       = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_done)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = stat.last_round ? ST_IDLE : ST_MODS;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

@@ rtl/core/josephus_elimination_order.sv @@
// ----------------------------------------------------------------------------
// josephus_elimination_order
// Emits the Josephus elimination order of one request as a run of 1-based
// positions, the final beat flagged by last_of_run.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   circle_size, step_count
//   out      out_valid / out_ready eliminated_position, last_of_run
//
// Each round first reduces step % alive in the bit-serial remainder unit,
// then scans s slots, one per cycle (s <= circle size).
// in_ready is high only between requests; a size of zero is taken and dropped.
// Reset clears the removed map, the scan and the sequencer; no clearing pass.
// The result register lets a round proceed while its predecessor waits; a
// stalled out channel holds the sequencer at the next emit.
// ----------------------------------------------------------------------------
module josephus_elimination_order
	import jos_pkg::*;
#(
	parameter int MAX_MEMBERS = MAX_MEMBERS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [SIZE_FIELD_W-1:0] circle_size,
	input  logic [STEP_FIELD_W-1:0] step_count,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [POS_FIELD_W-1:0]  eliminated_position,
	output logic                    last_of_run
);

	jos_cmd_t  cmd;
	jos_stat_t stat;

	jos_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd     (cmd),
		.stat    (stat)
	);

	jos_datapath #(
		.MAX_MEMBERS(MAX_MEMBERS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.stat               (stat),
		.circle_size        (circle_size),
		.step_count         (step_count),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.eliminated_position(eliminated_position),
		.last_of_run        (last_of_run)
	);

endmodule

@@ test/josephus_elimination_order_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// josephus_elimination_order_tb
// Sends circle size / step requests and checks every beat of the elimination
// order against a cycle-free software model of the Josephus permutation, with
// random idle gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module josephus_elimination_order_tb;
	import jos_pkg::*;

	localparam int MEMBERS_MAX = MAX_MEMBERS_DEF;

	typedef struct {
		logic [POS_FIELD_W-1:0] position;
		logic                   last;
	} elim_beat_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [SIZE_FIELD_W-1:0] circle_size;
	logic [STEP_FIELD_W-1:0] step_count;
	logic                    out_valid;
	logic                    out_ready;
	logic [POS_FIELD_W-1:0]  eliminated_position;
	logic                    last_of_run;

	elim_beat_t expected_order[$];
	elim_beat_t check_beat;
	int         errors;
	bit         in_gaps_on;
	bit         out_stalls_on;
	int         stall_left;

	josephus_elimination_order #(
		.MAX_MEMBERS(MEMBERS_MAX)
	) DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.circle_size        (circle_size),
		.step_count         (step_count),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.eliminated_position(eliminated_position),
		.last_of_run        (last_of_run)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// full elimination order of one request, queued as expected beats
	function automatic void predict_elimination_order(input logic [SIZE_FIELD_W-1:0] req_size,
			input logic [STEP_FIELD_W-1:0] req_step);
		logic [MEMBERS_MAX-1:0] removed;
		int unsigned members, alive, need, scan, victim, taken;
		elim_beat_t beat;
		members = int'(req_size);
		if (members == 0)
			return;
		if (members > MEMBERS_MAX)
			members = MEMBERS_MAX;
		removed = '0;
		scan = 0;
		for (int unsigned r = 0; r < members; r++) begin
			alive = members - r;
			need = int'(req_step) % alive;
			if (need == 0)
				need = alive;   // zero remainder: a full lap
			taken = 0;
			victim = 0;
			while (taken < need) begin
				if (!removed[scan]) begin
					victim = scan;
					taken++;
				end
				scan = (scan + 1) % members;
			end
			removed[victim] = 1'b1;
			beat.position = POS_FIELD_W'(victim + 1);
			beat.last = (r + 1 == members);
			expected_order.push_back(beat);
		end
	endfunction

	task automatic send_request(input logic [SIZE_FIELD_W-1:0] req_size,
			input logic [STEP_FIELD_W-1:0] req_step);
		int gap;
		gap = in_gaps_on ? random_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		circle_size <= req_size;
		step_count  <= req_step;
		do @(posedge clk); while (!in_ready);
		predict_elimination_order(req_size, req_step);
	endtask

	task automatic release_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_order.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random_request();
		logic [SIZE_FIELD_W-1:0] req_size;
		logic [STEP_FIELD_W-1:0] req_step;
		int r;
		r = $urandom_range(0, 99);
		if (r < 78)
			req_size = SIZE_FIELD_W'($urandom_range(1, 12));
		else if (r < 90)
			req_size = SIZE_FIELD_W'($urandom_range(13, 40));
		else if (r < 95)
			req_size = SIZE_FIELD_W'($urandom_range(41, 64));
		else if (r < 98)
			req_size = SIZE_FIELD_W'($urandom_range(65, 127));
		else
			req_size = '0;
		r = $urandom_range(0, 99);
		if (r < 45)
			req_step = STEP_FIELD_W'($urandom_range(1, 20));
		else if (r < 65)
			req_step = STEP_FIELD_W'($urandom_range(0, 3 * 64));
		else if (r < 95)
			req_step = STEP_FIELD_W'($urandom_range(0, 16'hFFFF));
		else
			req_step = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'h0000;
		send_request(req_size, req_step);
	endtask

	task automatic test_directed_cases();
		send_request(7'd1, 16'd1);
		send_request(7'd2, 16'd1);
		send_request(7'd2, 16'd2);
		send_request(7'd7, 16'd3);
		send_request(7'd5, 16'd0);        // zero step: every round a full lap
		send_request(7'd6, 16'd12);       // step a multiple of the size
		send_request(7'd10, 16'hFFFF);
		send_request(7'd0, 16'd5);        // empty circle: dropped
		send_request(7'd0, 16'd0);
		send_request(7'd64, 16'd1);
		send_request(7'd64, 16'hFFFF);
		send_request(7'd64, 16'd0);
		send_request(7'd127, 16'd2);      // oversized, saturates to full circle
		send_request(7'd65, 16'd7);
		send_request(7'd3, 16'h8000);
	endtask

	// sender holds off until every beat of the earlier requests is out
	task automatic test_drain_pause();
		for (int i = 0; i < 4; i++)
			send_random_request();
		release_input();
		wait_drained();
		for (int i = 0; i < 4; i++)
			send_random_request();
		release_input();
		wait_drained();
	endtask

	task automatic test_back_to_back();
		in_gaps_on = 1'b0;
		out_stalls_on = 1'b0;
		for (int i = 0; i < 12; i++)
			send_request(SIZE_FIELD_W'($urandom_range(1, 10)),
				STEP_FIELD_W'($urandom_range(0, 30)));
		in_gaps_on = 1'b1;
		out_stalls_on = 1'b1;
	endtask

	task automatic test_random_mix();
		for (int i = 0; i < 95; i++) begin
			// occasional stretch with no idling on either side
			if (i % 30 == 20) begin
				in_gaps_on = 1'b0;
				out_stalls_on = 1'b0;
			end else if (i % 30 == 26) begin
				in_gaps_on = 1'b1;
				out_stalls_on = 1'b1;
			end
			send_random_request();
		end
		in_gaps_on = 1'b1;
		out_stalls_on = 1'b1;
	endtask

	// result side back-pressure
	initial begin
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (out_stalls_on && $urandom_range(0, 3) == 0)
					stall_left = (random_gap() == 0) ? 1 : random_gap() + 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_order.size() == 0) begin
				$display("%0t: unexpected beat: position %0d last %0b", $time,
					eliminated_position, last_of_run);
				errors++;
			end else begin
				check_beat = expected_order.pop_front();
				if (eliminated_position !== check_beat.position) begin
					$display("%0t: eliminated_position: expected %0d, got %0d", $time,
						check_beat.position, eliminated_position);
					errors++;
				end
				if (last_of_run !== check_beat.last) begin
					$display("%0t: last_of_run: expected %0b, got %0b", $time,
						check_beat.last, last_of_run);
					errors++;
				end
			end
		end
	end

	initial begin
		#50ms;
		$display("tb: failure");
		$finish;
	end

	initial begin
		errors        = 0;
		in_gaps_on    = 1'b1;
		out_stalls_on = 1'b1;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		circle_size   = '0;
		step_count    = '0;
		out_ready     = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_drain_pause();
		test_back_to_back();
		test_random_mix();
		release_input();

		wait_drained();
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_order.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
